// File: design/kat_pkg.sv
// ---------------------------------------------------------------------------
// kat_pkg
// Types and codes shared by the keyed accumulate table: item layouts,
// operation and status codes, field widths.
// ---------------------------------------------------------------------------
package kat_pkg;

	// field widths
	localparam int FUNC_W  = 2;
	localparam int PART_W  = 8;
	localparam int KEY_W   = 3 * PART_W;
	localparam int TOTAL_W = 32;
	localparam int SLOT_W  = 6;
	localparam int STAT_W  = 2;
	localparam int LIVE_W  = 7;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NEW      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_SLOT = 2'd3;

	// request item
	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [PART_W-1:0]  key_race;
		logic [PART_W-1:0]  key_culture;
		logic [PART_W-1:0]  key_religion;
		logic [TOTAL_W-1:0] amount;
		logic [SLOT_W-1:0]  slot;
	} req_t;

	// response item
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SLOT_W-1:0]  slot_used;
		logic [PART_W-1:0]  out_race;
		logic [PART_W-1:0]  out_culture;
		logic [PART_W-1:0]  out_religion;
		logic [TOTAL_W-1:0] out_total;
		logic [LIVE_W-1:0]  live_entries;
	} rsp_t;

	// stored entry payload
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [TOTAL_W-1:0] total;
	} entry_t;

endpackage

// File: design/kat_store.sv
// ---------------------------------------------------------------------------
// kat_store
// Entry storage: a one-bit valid memory and a key/total memory sharing one
// address space, one write port each, one registered read port.
// ---------------------------------------------------------------------------
module kat_store #(
	parameter int CAPACITY = 64
) (
	input  logic                         clk,
	input  logic                         wr_vld_en,
	input  logic                         wr_vld,
	input  logic                         wr_dat_en,
	input  logic [$clog2(CAPACITY)-1:0]  wr_addr,
	input  kat_pkg::entry_t              wr_entry,
	input  logic                         rd_en,
	input  logic [$clog2(CAPACITY)-1:0]  rd_addr,
	output logic                         rd_vld,
	output kat_pkg::entry_t              rd_entry
);
	import kat_pkg::*;

	logic   vld_mem [CAPACITY];
	entry_t dat_mem [CAPACITY];

	// valid bits, cleared by the sequencer sweep after reset
	always_ff @(posedge clk) begin
		if (wr_vld_en) begin
			vld_mem[wr_addr] <= wr_vld;
		end
		if (rd_en) begin
			rd_vld <= vld_mem[rd_addr];
		end
	end

	// key and total, meaningful only where the valid bit is set
	always_ff @(posedge clk) begin
		if (wr_dat_en) begin
			dat_mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry <= dat_mem[rd_addr];
		end
	end

endmodule

// File: design/kat_alu.sv
// ---------------------------------------------------------------------------
// kat_alu
// Shared compare and accumulate unit: key equality against the stored entry
// and a saturating add of the amount to the stored total.
// ---------------------------------------------------------------------------
module kat_alu (
	input  logic [kat_pkg::KEY_W-1:0]   key_a,
	input  logic [kat_pkg::KEY_W-1:0]   key_b,
	input  logic [kat_pkg::TOTAL_W-1:0] total,
	input  logic [kat_pkg::TOTAL_W-1:0] amount,
	output logic                        key_eq,
	output logic [kat_pkg::TOTAL_W-1:0] sum
);
	import kat_pkg::*;

	logic [TOTAL_W:0] raw_sum;

	// key match
	assign key_eq = (key_a == key_b);

	// add with clamp on carry out
	assign raw_sum = {1'b0, total} + {1'b0, amount};
	assign sum     = raw_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : raw_sum[TOTAL_W-1:0];

endmodule

// File: design/keyed_accumulate_table_unit.sv
// ---------------------------------------------------------------------------
// keyed_accumulate_table_unit
// Group-by-sum table: add merges into an entry with an equal key or takes
// the lowest free slot, remove frees a slot, read returns a slot.
// ---------------------------------------------------------------------------
//  channel | signals                    | direction | accepted when
//  --------+----------------------------+-----------+-----------------------
//  request | req_valid, req_ready, req  | in        | req_valid & req_ready
//  result  | rsp_valid, rsp_ready, rsp  | out       | rsp_valid & rsp_ready
//
//  one item at a time; an add scans the table from accept to result, stopping
//  early on a match, and the scan reads one stored entry per cycle through the
//  single read port; remove and read take a read step and an evaluate step.
//  after reset a clearing sweep over every slot resets the valid memory;
//  req_ready stays low until it ends.
//  a result waits in the output register while rsp_ready is low; the next
//  item is taken meanwhile but its result holds until the register frees.
// ---------------------------------------------------------------------------
module keyed_accumulate_table_unit #(
	parameter int CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  kat_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kat_pkg::rsp_t rsp
);
	import kat_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int RNG_W = (CNT_W > SLOT_W + 1) ? CNT_W : SLOT_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [RNG_W-1:0] CAP_RNG  = RNG_W'(CAPACITY);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ACC_RD,
		S_ACC_EV,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    addr_q;
	logic                issue_done_q;
	logic                cmp_v_s1;
	logic [IDX_W-1:0]    cmp_idx_s1;
	logic                have_free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [CNT_W-1:0]    count_q;
	logic [FUNC_W-1:0]   func_q;
	logic [KEY_W-1:0]    key_q;
	logic [TOTAL_W-1:0]  amount_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                in_range_q;
	rsp_t                res_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic                wr_vld_en;
	logic                wr_vld;
	logic                wr_dat_en;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_entry;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                rd_vld;
	entry_t              rd_entry;
	logic                key_eq;
	logic [TOTAL_W-1:0]  sum;

	logic [RNG_W-1:0]    slot_ext;
	logic [IDX_W-1:0]    slot_idx;
	logic                hit;
	logic                cand_free;
	logic                scan_end;
	logic                free_any;
	logic [IDX_W-1:0]    alloc_idx;
	logic                acc_ok;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// slot of a remove or read, in table index width
	assign slot_ext = RNG_W'(slot_q);
	assign slot_idx = slot_ext[IDX_W-1:0];

	// storage
	kat_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk       (clk),
		.wr_vld_en (wr_vld_en),
		.wr_vld    (wr_vld),
		.wr_dat_en (wr_dat_en),
		.wr_addr   (wr_addr),
		.wr_entry  (wr_entry),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_vld    (rd_vld),
		.rd_entry  (rd_entry)
	);

	// compare and accumulate on the entry just read
	kat_alu u_alu (
		.key_a  (rd_entry.key),
		.key_b  (key_q),
		.total  (rd_entry.total),
		.amount (amount_q),
		.key_eq (key_eq),
		.sum    (sum)
	);

	// scan decisions on the entry returned this cycle
	always_comb begin
		hit       = (state_q == S_SCAN) && cmp_v_s1 && rd_vld && key_eq;
		cand_free = (state_q == S_SCAN) && cmp_v_s1 && !rd_vld && !have_free_q;
		scan_end  = (state_q == S_SCAN) && cmp_v_s1 && (cmp_idx_s1 == LAST_IDX) && !hit;
		free_any  = have_free_q || cand_free;
		alloc_idx = have_free_q ? free_idx_q : cmp_idx_s1;
		acc_ok    = ((func_q == FUNC_REMOVE) || (func_q == FUNC_READ)) && in_range_q && rd_vld;
	end

	// memory port control
	always_comb begin
		rd_en          = ((state_q == S_SCAN) && !issue_done_q) || (state_q == S_ACC_RD);
		rd_addr        = (state_q == S_ACC_RD) ? slot_idx : addr_q;
		wr_vld_en      = 1'b0;
		wr_vld         = 1'b0;
		wr_dat_en      = 1'b0;
		wr_addr        = addr_q;
		wr_entry.key   = key_q;
		wr_entry.total = amount_q;
		unique case (state_q)
			S_CLEAR: begin
				wr_vld_en = 1'b1;
			end
			S_SCAN: begin
				if (hit) begin
					wr_dat_en      = 1'b1;
					wr_addr        = cmp_idx_s1;
					wr_entry.total = sum;
				end else if (scan_end && free_any) begin
					wr_vld_en = 1'b1;
					wr_vld    = 1'b1;
					wr_dat_en = 1'b1;
					wr_addr   = alloc_idx;
				end
			end
			S_ACC_EV: begin
				if (acc_ok && (func_q == FUNC_REMOVE)) begin
					wr_vld_en = 1'b1;
					wr_addr   = slot_idx;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer with result and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			cmp_v_s1     <= 1'b0;
			cmp_idx_s1   <= '0;
			have_free_q  <= 1'b0;
			free_idx_q   <= '0;
			count_q      <= '0;
			func_q       <= '0;
			key_q        <= '0;
			amount_q     <= '0;
			slot_q       <= '0;
			in_range_q   <= 1'b0;
			res_q        <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// drop the output once taken, unless a new result replaces it
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == LAST_IDX) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + IDX_W'(1);
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						func_q       <= req.func;
						key_q        <= {req.key_race, req.key_culture, req.key_religion};
						amount_q     <= req.amount;
						slot_q       <= req.slot;
						in_range_q   <= (RNG_W'(req.slot) < CAP_RNG);
						addr_q       <= '0;
						issue_done_q <= 1'b0;
						cmp_v_s1     <= 1'b0;
						have_free_q  <= 1'b0;
						state_q      <= (req.func == FUNC_ADD) ? S_SCAN : S_ACC_RD;
					end
				end
				S_SCAN: begin
					// issue side
					if (!issue_done_q) begin
						addr_q <= addr_q + IDX_W'(1);
						if (addr_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end
					end
					cmp_v_s1   <= !issue_done_q;
					cmp_idx_s1 <= addr_q;
					// lowest free slot seen so far
					if (cand_free) begin
						have_free_q <= 1'b1;
						free_idx_q  <= cmp_idx_s1;
					end
					if (hit) begin
						res_q.status       <= STAT_OK;
						res_q.slot_used    <= SLOT_W'(cmp_idx_s1);
						res_q.out_race     <= key_q[KEY_W-1 -: PART_W];
						res_q.out_culture  <= key_q[PART_W +: PART_W];
						res_q.out_religion <= key_q[PART_W-1:0];
						res_q.out_total    <= sum;
						res_q.live_entries <= LIVE_W'(count_q);
						state_q            <= S_DONE;
					end else if (scan_end) begin
						if (free_any) begin
							count_q            <= count_q + CNT_W'(1);
							res_q.status       <= STAT_NEW;
							res_q.slot_used    <= SLOT_W'(alloc_idx);
							res_q.out_race     <= key_q[KEY_W-1 -: PART_W];
							res_q.out_culture  <= key_q[PART_W +: PART_W];
							res_q.out_religion <= key_q[PART_W-1:0];
							res_q.out_total    <= amount_q;
							res_q.live_entries <= LIVE_W'(count_q + CNT_W'(1));
						end else begin
							res_q.status       <= STAT_FULL;
							res_q.slot_used    <= '0;
							res_q.out_race     <= '0;
							res_q.out_culture  <= '0;
							res_q.out_religion <= '0;
							res_q.out_total    <= '0;
							res_q.live_entries <= LIVE_W'(count_q);
						end
						state_q <= S_DONE;
					end
				end
				S_ACC_RD: begin
					state_q <= S_ACC_EV;
				end
				S_ACC_EV: begin
					res_q.slot_used <= slot_q;
					if (acc_ok) begin
						res_q.status       <= STAT_OK;
						res_q.out_race     <= rd_entry.key[KEY_W-1 -: PART_W];
						res_q.out_culture  <= rd_entry.key[PART_W +: PART_W];
						res_q.out_religion <= rd_entry.key[PART_W-1:0];
						res_q.out_total    <= rd_entry.total;
						if (func_q == FUNC_REMOVE) begin
							count_q            <= count_q - CNT_W'(1);
							res_q.live_entries <= LIVE_W'(count_q - CNT_W'(1));
						end else begin
							res_q.live_entries <= LIVE_W'(count_q);
						end
					end else begin
						res_q.status       <= STAT_BAD_SLOT;
						res_q.out_race     <= '0;
						res_q.out_culture  <= '0;
						res_q.out_religion <= '0;
						res_q.out_total    <= '0;
						res_q.live_entries <= LIVE_W'(count_q);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hand the result over once the output register is free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
